### design/parabolic_peak_picker_top_assert.svh
// ----------------------------------------------------------------------------
// Parabolic peak picker assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled while arst_n is
// low. They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PARABOLIC_PEAK_PICKER_TOP_ASSERT_SVH
`define PARABOLIC_PEAK_PICKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PPP_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define PPP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define PPP_ASSERT_NOW(name, ante, cons)
`define PPP_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### design/ppp_pkg.sv
// ----------------------------------------------------------------------------
// Parabolic peak picker package
// Shared widths, defaults and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_pkg;

	localparam int DEF_MAX_LENGTH = 4096;
	localparam int DEF_FRAC_BITS  = 8;

	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 20;
	localparam int VAL_W    = 25;
	localparam int THR_W    = 25;

	// Divider operands: dividend is |older - current|, divisor is
	// 2 * (2 * middle - older - current), always positive for a strict maximum.
	localparam int DVD_W = 16;
	localparam int DVS_W = 18;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - POS_W - VAL_W;

	localparam logic [POS_W-1:0]        POS_MAX = '1;
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_UPD,
		ST_FIN
	} ppp_state_t;

endpackage

`default_nettype wire

### design/parabolic_peak_picker_top.sv
// ----------------------------------------------------------------------------
// Parabolic peak picker
// Finds the strongest interpolated local maximum of a sample frame.
// ----------------------------------------------------------------------------
// Samples arrive one per transfer on the slave stream, with tlast on the final
// sample of a frame. Each time the middle sample of the three-sample window is
// a strict local maximum, a parabola is fitted through the window and its
// vertex value and position (both with FRAC_BITS fractional bits) replace the
// best so far when the value beats the best by more than update_threshold.
// After the sample carrying tlast one transfer on the master stream gives the
// best position and value, or zeros when nothing qualified, and the frame
// state is cleared. A peak goes through the serial divider, which produces one
// quotient bit per cycle, then a multiply state and a compare-and-update state.
// The sample with tlast then loads the output register, which waits there for
// the master side; a result still waiting holds the next frame end off. The
// threshold register accepts writes at any time but must only be written
// between frames.
// ----------------------------------------------------------------------------
`default_nettype none

`include "parabolic_peak_picker_top_assert.svh"

module parabolic_peak_picker_top
	import ppp_pkg::*;
#(
	parameter int MAX_LENGTH = DEF_MAX_LENGTH,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Slave stream; tdata: [15:0] sample (signed). tlast: last_sample.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tlast,
	// Master stream; tdata: [19:0] peak_position, [44:20] peak_value (signed),
	// [47:45] zero.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// Threshold register write channel; data is update_threshold (signed).
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [THR_W-1:0]       cfg_data
);

	// Sample counter holds up to MAX_LENGTH - 1.
	localparam int CNT_W = $clog2(MAX_LENGTH);
	// Ratio r lies strictly between one half and three halves.
	localparam int RW    = FRAC_BITS + 1;
	// Unsigned product r * (middle - older).
	localparam int PRD_W = RW + SAMPLE_W;
	// Candidate value needs FRAC_BITS + 18 bits; the comparison also covers the
	// sum of the best value and the threshold.
	localparam int VW    = FRAC_BITS + 18;
	localparam int CW    = ((VW > VAL_W + 1) ? VW : (VAL_W + 1)) + 1;
	// Unsigned position before clamping.
	localparam int PW    = CNT_W + FRAC_BITS + 1;
	localparam int PCW   = (PW > POS_W) ? PW : POS_W;

	localparam logic [RW-1:0] ONE  = RW'(1) << FRAC_BITS;
	localparam logic [RW-1:0] HALF = RW'(1) << (FRAC_BITS - 1);

	ppp_state_t state_q, state_d;

	// Threshold register.
	logic signed [THR_W-1:0] thr_q;

	// Frame state.
	logic signed [SAMPLE_W-1:0] older_q, newer_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [VAL_W-1:0]    best_val_q;
	logic [POS_W-1:0]           best_pos_q;

	// Working registers of the peak currently under evaluation.
	logic signed [SAMPLE_W-1:0] prev_q;
	logic [SAMPLE_W-1:0]        rise_q;
	logic                       neg_q;
	logic [CNT_W-1:0]           idx_q;
	logic                       last_q;
	logic [RW-1:0]              r_q;
	logic [PRD_W-1:0]           prod_q;

	// Output register.
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// Handshake and sequencer controls.
	logic in_acc, is_peak, div_start, fin_go;

	// Window arithmetic of the incoming sample.
	logic signed [SAMPLE_W-1:0] cur;
	logic signed [SAMPLE_W:0]   diff_oc, rise;
	logic [DVD_W-1:0]           dvd_mag;
	logic signed [SAMPLE_W+2:0] den_half;
	logic [DVS_W-1:0]           dvs;

	// Divider.
	logic                 div_done;
	logic [FRAC_BITS-1:0] div_quo;

	// Update stage.
	logic signed [CW-1:0]  val_full, limit;
	logic signed [VAL_W-1:0] val_sat;
	logic [PW-1:0]         pos_full;
	logic [POS_W-1:0]      pos_sat;

	assign cfg_ready = 1'b1;

	assign cur      = s_axis_tdata[SAMPLE_W-1:0];
	assign diff_oc  = {older_q[SAMPLE_W-1], older_q} - {cur[SAMPLE_W-1], cur};
	assign rise     = {newer_q[SAMPLE_W-1], newer_q} - {older_q[SAMPLE_W-1], older_q};
	assign dvd_mag  = diff_oc[SAMPLE_W] ? DVD_W'(-diff_oc) : DVD_W'(diff_oc);
	assign den_half = (SAMPLE_W+3)'(newer_q) + (SAMPLE_W+3)'(newer_q)
	                - (SAMPLE_W+3)'(older_q) - (SAMPLE_W+3)'(cur);
	assign dvs      = {den_half[DVS_W-2:0], 1'b0};

	assign is_peak = (cnt_q >= CNT_W'(2)) && (newer_q > older_q) && (cur < newer_q);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (is_peak) begin
						state_d = ST_DIV;
					end else if (s_axis_tlast) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_UPD;
			ST_UPD: state_d = last_q ? ST_FIN : ST_IDLE;
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		in_acc        = s_axis_tvalid && (state_q == ST_IDLE);
		div_start     = in_acc && is_peak;
		fin_go        = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	ppp_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_mag),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Capture the window of each accepted sample, then form r and the product of a peak.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			prev_q <= older_q;
			rise_q <= rise[SAMPLE_W-1:0];
			// Older above current gives a negative vertex offset.
			neg_q  <= !diff_oc[SAMPLE_W] && (diff_oc != '0);
			idx_q  <= cnt_q - 1'b1;
			last_q <= s_axis_tlast;
		end
		if ((state_q == ST_DIV) && div_done) begin
			r_q <= neg_q ? (ONE - RW'(div_quo)) : (ONE + RW'(div_quo));
		end
		if (state_q == ST_MUL) begin
			prod_q <= PRD_W'(r_q) * PRD_W'(rise_q);
		end
	end

	assign val_full = (CW'(prev_q) <<< FRAC_BITS) + CW'(prod_q);
	assign limit    = CW'(best_val_q) + CW'(thr_q);
	assign val_sat  = (val_full > CW'(VAL_MAX)) ? VAL_MAX :
	                  (val_full < CW'(VAL_MIN)) ? VAL_MIN : val_full[VAL_W-1:0];
	assign pos_full = (PW'(idx_q) << FRAC_BITS) + PW'(r_q);
	assign pos_sat  = (PCW'(pos_full) > PCW'(POS_MAX)) ? POS_MAX : POS_W'(pos_full);

	// Frame state: window shift on each transfer, best update, clear at frame end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q    <= '0;
			newer_q    <= '0;
			cnt_q      <= '0;
			best_val_q <= '0;
			best_pos_q <= '0;
		end else begin
			if (in_acc) begin
				older_q <= newer_q;
				newer_q <= cur;
				if (cnt_q < CNT_W'(MAX_LENGTH - 1)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if ((state_q == ST_UPD) && (val_full > limit)) begin
				best_val_q <= val_sat;
				best_pos_q <= pos_sat;
			end
			if (fin_go) begin
				older_q    <= '0;
				newer_q    <= '0;
				cnt_q      <= '0;
				best_val_q <= '0;
				best_pos_q <= '0;
			end
		end
	end

	// Output register; it frees as soon as the master side takes the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fin_go) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			m_data_q <= {{OUT_PAD_W{1'b0}}, best_val_q, best_pos_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// A frame end always goes either to the divider or straight to the output.
	`PPP_ASSERT_NEXT(a_last_leads_on, in_acc && s_axis_tlast, (state_q == ST_DIV) || (state_q == ST_FIN))
	// The divider finishes only while the sequencer waits for it.
	`PPP_ASSERT_NOW(a_div_done_in_div, div_done, state_q == ST_DIV)
	// The vertex lies less than half a sample from the middle sample.
	`PPP_ASSERT_NOW(a_ratio_range, state_q == ST_MUL, (r_q > HALF) && (r_q < (ONE + HALF)))

endmodule

`default_nettype wire

### design/ppp_div.sv
// ----------------------------------------------------------------------------
// Parabolic peak picker serial divider
// Restoring shift-subtract divider, one quotient bit per cycle. The dividend
// is known to be below the divisor, so FRAC_BITS steps give the whole
// fractional quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_div
	import ppp_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DVD_W-1:0]     dividend,
	input  logic [DVS_W-1:0]     divisor,
	output logic                 done,
	output logic [FRAC_BITS-1:0] quotient
);

	localparam int RM_W  = DVS_W + 1;
	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [RM_W-1:0]      rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [RM_W-1:0]      trial;
	logic                 fits;

	assign trial = {rem_q[RM_W-2:0], 1'b0};
	assign fits  = (trial >= RM_W'(dvs_q));

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(FRAC_BITS);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RM_W'(dividend);
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= fits ? (trial - RM_W'(dvs_q)) : trial;
			quo_q <= {quo_q[FRAC_BITS-2:0], fits};
		end
	end

endmodule

`default_nettype wire

### dv/tb_parabolic_peak_picker_top.sv
// ----------------------------------------------------------------------------
// Parabolic peak picker testbench
// Streams sample frames through the block under changing threshold settings
// and compares every peak report against a cycle-free prediction or a typed one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_parabolic_peak_picker_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ppp_pkg::*;

	localparam int     MAX_LENGTH    = DEF_MAX_LENGTH;
	localparam int     FRAC_BITS     = DEF_FRAC_BITS;
	localparam longint UNIT          = longint'(1) << FRAC_BITS;
	// This margin outlasts any work still inside the block after a report.
	localparam int     SETTLE_CYCLES = FRAC_BITS + 12;
	localparam int     PHASES        = 8;
	localparam int     PHASE_SAMPLES = 170;
	localparam int     SHOWN_ERRORS  = 10;

	// One peak report as it leaves on the master stream.
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
	} peak_report_t;

	// One row of the directed table. When typed is set, the report that the
	// row closes is the one given here rather than the predicted one.
	typedef struct packed {
		logic [SAMPLE_W-1:0] smp;
		logic                last;
		logic                typed;
		peak_report_t        report;
	} frame_row_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// tdata: [15:0] sample (signed).
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   s_axis_tlast  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// tdata: [19:0] peak_position, [44:20] peak_value (signed), [47:45] zero.
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [THR_W-1:0]       cfg_data      = '0;

	parabolic_peak_picker_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Predicted block state: the sample window, the per-frame count, the best
	// candidate so far and the threshold register.
	logic signed [SAMPLE_W-1:0] win_older   = '0;
	logic signed [SAMPLE_W-1:0] win_newer   = '0;
	logic [11:0]                frame_count = '0;
	logic signed [VAL_W-1:0]    best_val    = '0;
	logic [POS_W-1:0]           best_pos    = '0;
	logic signed [THR_W-1:0]    margin      = '0;

	// Reports predicted but not yet seen on the master stream, oldest first.
	peak_report_t pending_reports [$];

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int samples_sent   = 0;
	int frames_sent    = 0;
	int reports_seen   = 0;
	int margin_writes  = 0;
	int mismatches     = 0;

	// Directed frames, each closed by its tlast sample:
	//  - a lone sample and a two-sample frame, too short for any window;
	//  - full-scale symmetric peak, judged on the last sample itself;
	//  - full-scale lopsided peak, the widest interpolated value;
	//  - a peak whose value is negative, so it never beats the initial best;
	//  - two equal peaks, where the first must be kept;
	//  - a small peak followed by a larger one that replaces it;
	//  - a flat plateau, which is no strict maximum.
	frame_row_t directed_rows [27] = '{
		'{16'sd1234,  1'b1, 1'b1, '{20'd0, 25'd0}},
		'{16'h7FFF,   1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'h8000,   1'b1, 1'b1, '{20'd0, 25'd0}},
		'{16'h8000,   1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'h7FFF,   1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'h8000,   1'b1, 1'b1, '{20'd512, 25'd8388352}},
		'{16'h8000,   1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'h7FFF,   1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'h7FFE,   1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'sd0,     1'b1, 1'b0, '{20'd0, 25'd0}},
		'{-16'sd100,  1'b0, 1'b0, '{20'd0, 25'd0}},
		'{-16'sd50,   1'b0, 1'b0, '{20'd0, 25'd0}},
		'{-16'sd100,  1'b1, 1'b1, '{20'd0, 25'd0}},
		'{16'sd0,     1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'sd1000,  1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'sd0,     1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'sd1000,  1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'sd0,     1'b1, 1'b0, '{20'd0, 25'd0}},
		'{16'sd0,     1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'sd100,   1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'sd0,     1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'sd500,   1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'sd200,   1'b0, 1'b0, '{20'd0, 25'd0}},
		'{-16'sd5,    1'b1, 1'b0, '{20'd0, 25'd0}},
		'{16'sd5,     1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'sd5,     1'b0, 1'b0, '{20'd0, 25'd0}},
		'{16'sd5,     1'b1, 1'b1, '{20'd0, 25'd0}}
	};

	// Clock, 12 ns period.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#12ms;
		$display("timeout: %0d reports still outstanding", pending_reports.size());
		$display("parabolic_peak_picker_top: mismatch");
		$finish;
	end

	// Advances the predicted state by one accepted sample. Returns 1 when the
	// sample closes the frame, with the report the block must then send.
	function automatic logic fold_sample(input logic signed [SAMPLE_W-1:0] cur,
			input logic last, output peak_report_t report);
		longint prev;
		longint mid;
		longint now_s;
		longint den;
		longint offset;
		longint ratio;
		longint value;
		longint spot;
		report = '0;
		prev   = win_older;
		mid    = win_newer;
		now_s  = cur;
		// The window is judged before the new sample shifts in, so the sample
		// that carries tlast still takes part.
		if (frame_count >= 2 && mid > prev && now_s < mid) begin
			den    = 2 * (prev - 2 * mid + now_s);
			offset = ((prev - now_s) * UNIT) / den;
			ratio  = offset + UNIT;
			value  = prev * UNIT + ratio * (mid - prev);
			// The comparison runs at full width; only the stored copy saturates.
			if (value > longint'(best_val) + longint'(margin)) begin
				if (value > longint'(VAL_MAX))
					value = longint'(VAL_MAX);
				else if (value < longint'(VAL_MIN))
					value = longint'(VAL_MIN);
				best_val = VAL_W'(value);
				spot = (longint'(frame_count) - 1) * UNIT + ratio;
				if (spot > longint'(POS_MAX))
					spot = longint'(POS_MAX);
				else if (spot < 0)
					spot = 0;
				best_pos = POS_W'(spot);
			end
		end
		win_older = win_newer;
		win_newer = cur;
		// Long frames pin the count, which pins the peak index as well.
		if (frame_count < MAX_LENGTH - 1)
			frame_count++;
		if (last) begin
			report.pos  = best_pos;
			report.val  = best_val;
			win_older   = '0;
			win_newer   = '0;
			frame_count = '0;
			best_val    = '0;
			best_pos    = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Offers one sample on the slave stream, after a random gap when the phase
	// asks for one, and predicts its effect once the transfer completes.
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic last,
			input logic given, input peak_report_t given_report);
		peak_report_t report;
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		samples_sent++;
		if (last)
			frames_sent++;
		if (fold_sample(smp, last, report))
			pending_reports.push_back(given ? given_report : report);
	endtask

	// Holds the sender off until every predicted report has arrived, then lets
	// the block settle. Always called right after a frame has closed.
	task automatic wait_for_reports();
		s_axis_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the threshold register through its own channel.
	task automatic write_margin(input logic [THR_W-1:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		margin = value;
		margin_writes++;
	endtask

	// Sends one random frame. Most frames are short; a few are long enough to
	// hold many candidate peaks. The sample style varies from frame to frame.
	task automatic send_random_frame();
		int                  len;
		int                  style;
		int                  walk;
		int                  v;
		logic [SAMPLE_W-1:0] smp;
		v     = $urandom_range(99);
		len   = (v < 8) ? $urandom_range(1, 2)
			: ((v < 92) ? $urandom_range(3, 30) : $urandom_range(31, 160));
		style = $urandom_range(3);
		walk  = int'($urandom_range(65535)) - 32768;
		for (int i = 0; i < len; i++) begin
			case (style)
				0: smp = SAMPLE_W'($urandom);
				1: begin
					v   = int'($urandom_range(64)) - 32;
					smp = v[SAMPLE_W-1:0];
				end
				2: begin
					// Random walk: smooth bumps with realistic curvature.
					walk = walk + int'($urandom_range(4000)) - 2000;
					if (walk > 32767)
						walk = 32767;
					else if (walk < -32768)
						walk = -32768;
					smp = walk[SAMPLE_W-1:0];
				end
				default: begin
					case ($urandom_range(4))
						0: smp = 16'h8000;
						1: smp = 16'h7FFF;
						2: smp = 16'h7FFE;
						3: smp = 16'h8001;
						default: smp = '0;
					endcase
				end
			endcase
			send_sample(smp, i == len - 1, 1'b0, '0);
		end
	endtask

	// Result side: checks each transfer against the oldest prediction and
	// stalls at random as the current phase asks.
	initial begin
		peak_report_t want;
		logic [POS_W-1:0] got_pos;
		logic [VAL_W-1:0] got_val;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got_pos = m_axis_tdata[POS_W-1:0];
				got_val = m_axis_tdata[POS_W+VAL_W-1:POS_W];
				reports_seen++;
				if (pending_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("unexpected report: pos %0d value %0d", got_pos,
							$signed(got_val));
				end else begin
					want = pending_reports.pop_front();
					if (got_pos !== want.pos || got_val !== want.val
							|| m_axis_tdata[OUT_TDATA_W-1:POS_W+VAL_W] !== '0) begin
						mismatches++;
						if (mismatches <= SHOWN_ERRORS)
							$display("report %0d: expected pos %0d value %0d, got pos %0d value %0d pad %0h",
								reports_seen, want.pos, $signed(want.val), got_pos,
								$signed(got_val), m_axis_tdata[OUT_TDATA_W-1:POS_W+VAL_W]);
					end
				end
			end
			m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stimulus: reset, the directed table at the reset threshold, then random
	// phases, each with its own threshold and one of four idling patterns.
	initial begin
		logic [THR_W-1:0]    thr;
		int                  thr_pick;
		int                  phase_start;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_sample(directed_rows[i].smp, directed_rows[i].last,
				directed_rows[i].typed, directed_rows[i].report);

		for (int phase = 0; phase < PHASES; phase++) begin
			// The register is only written between frames, with nothing in flight.
			wait_for_reports();
			case (phase)
				0: thr = '0;
				1: thr = VAL_MAX;
				2: thr = VAL_MIN;
				3: thr = THR_W'($urandom_range(4000));
				4: begin
					thr_pick = -int'($urandom_range(1, 4000));
					thr      = thr_pick[THR_W-1:0];
				end
				5: thr = THR_W'($urandom);
				6: thr = THR_W'($urandom_range(300000));
				default: begin
					thr_pick = -int'($urandom_range(2000000));
					thr      = thr_pick[THR_W-1:0];
				end
			endcase
			write_margin(thr);

			// No idling, sender mostly idle, receiver mostly stalled, both light.
			case (phase % 4)
				0: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct   = 83;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct   = 0;
					recv_stall_pct = 83;
				end
				default: begin
					send_gap_pct   = 8;
					recv_stall_pct = 8;
				end
			endcase

			phase_start = samples_sent;
			while (samples_sent - phase_start < PHASE_SAMPLES)
				send_random_frame();
		end

		wait_for_reports();

		$display("covered %0d samples in %0d frames, from lone samples to long runs,",
			samples_sent, frames_sent);
		$display("over %0d threshold settings and four idling patterns; %0d reports checked",
			margin_writes, reports_seen);
		if (mismatches == 0) begin
			$display("parabolic_peak_picker_top: match");
		end else begin
			$display("%0d reports differed", mismatches);
			$display("parabolic_peak_picker_top: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire

### parabolic_peak_picker_top.f
+incdir+design
design/ppp_pkg.sv
design/ppp_div.sv
design/parabolic_peak_picker_top.sv
dv/tb_parabolic_peak_picker_top.sv
